// File: hdl/mmcm_cw_pkg.sv
// constants for the clock-manager counter word calculator
// reciprocal multipliers and field widths used by mmcm_counter_word_calc_unit
// no dependencies
package mmcm_cw_pkg;

    // input and output field widths
    localparam int DIV_W    = 8;
    localparam int DUTY_W   = 17;
    localparam int PHASE_W  = 20;
    localparam int WORD1_W  = 16;
    localparam int WORD2_W  = 8;

    // duty_q10 = floor(duty * 1024 / 100000) = floor(duty * 32 / 3125)
    localparam int DN_W     = DUTY_W + 5;
    localparam int DPROD_W  = 43;
    localparam logic [DPROD_W-1:0] DUTY_RECIP = 43'd1374389;   // floor(2^32 / 3125)
    localparam logic [DN_W:0]      DUTY_DIV   = 23'd3125;
    localparam int DFIX_W   = 11;

    // phase_fix magnitude = floor(|v| * 128 / 125)
    localparam logic signed [PHASE_W:0] FULL_TURN = 21'sd360000;
    localparam int AMAG_W   = 19;
    localparam int A128_W   = AMAG_W + 7;
    localparam int PPROD_W  = 52;
    localparam logic [PPROD_W-1:0] PH_RECIP   = 52'd34359738;  // floor(2^32 / 125)
    localparam logic [A128_W-1:0]  PH_DIV     = 26'd125;
    localparam int QA_W     = 20;

    // cycles = floor(p / 360) = floor((p >> 3) / 45)
    localparam int PM_W     = QA_W + DIV_W;
    localparam int N3_W     = 29;
    localparam int CPROD_W  = 59;
    localparam logic [CPROD_W-1:0] CYC_RECIP  = 59'd763549741; // floor(2^35 / 45)
    localparam logic [N3_W-1:0]    CYC_DIV    = 29'd45;
    localparam int PCYC_W   = 24;

    // pipeline depth
    localparam int STAGES   = 7;

endpackage

// File: hdl/mmcm_counter_word_calc_unit.sv
// clock-manager counter word calculator, seven-stage pipeline
// depends on mmcm_cw_pkg for widths and reciprocal constants

// Takes one counter request (divide, duty in thousandths of a percent, phase in
// thousandths of a degree) per clock unless the output stalls, and returns the
// two reconfiguration words for that counter from the output register of the
// seventh stage; throughput is one word per cycle unless the output stalls.
// The stages are the phase wrap stage, two reciprocal multiply and correction
// stage pairs (the divisions by 100000 and 1000 run side by side, the one by
// 360 comes after the divide multiply and the rounding and clamping stage). Each
// stage has its own valid bit and takes a new word whenever it is empty or its
// successor moves, so bubbles collapse and a stall on the output loses nothing.
module mmcm_counter_word_calc_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mmcm_cw_pkg::DIV_W-1:0]        i_divide,
    input  logic [mmcm_cw_pkg::DUTY_W-1:0]       i_duty,
    input  logic signed [mmcm_cw_pkg::PHASE_W-1:0] i_phase,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mmcm_cw_pkg::WORD1_W-1:0]      o_first_word,
    output logic [mmcm_cw_pkg::WORD2_W-1:0]      o_second_word
);

    localparam int NS = mmcm_cw_pkg::STAGES;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_rdy;

    // stage 1
    logic [mmcm_cw_pkg::DIV_W-1:0]   r1_div;
    logic [mmcm_cw_pkg::DN_W-1:0]    r1_dn;
    logic [mmcm_cw_pkg::A128_W-1:0]  r1_a128;
    logic                            r1_neg;
    logic signed [mmcm_cw_pkg::PHASE_W:0] n1_v;
    logic [mmcm_cw_pkg::PHASE_W:0]   n1_abs;
    // stage 2
    logic [mmcm_cw_pkg::DIV_W-1:0]   r2_div;
    logic [mmcm_cw_pkg::DN_W-1:0]    r2_dn;
    logic [mmcm_cw_pkg::A128_W-1:0]  r2_a128;
    logic                            r2_neg;
    logic [mmcm_cw_pkg::DPROD_W-1:0] r2_dprod;
    logic [mmcm_cw_pkg::PPROD_W-1:0] r2_pprod;
    // stage 3
    logic [mmcm_cw_pkg::DIV_W-1:0]   r3_div;
    logic [mmcm_cw_pkg::DFIX_W-1:0]  r3_dfix;
    logic [mmcm_cw_pkg::QA_W-1:0]    r3_qa;
    logic                            r3_neg;
    logic [mmcm_cw_pkg::DFIX_W-1:0]  n3_dq0;
    logic [mmcm_cw_pkg::DN_W:0]      n3_drem;
    logic [mmcm_cw_pkg::QA_W-1:0]    n3_pq0;
    logic [mmcm_cw_pkg::A128_W-1:0]  n3_prem;
    // stage 4
    logic [mmcm_cw_pkg::DIV_W-1:0]   r4_div;
    logic [18:0]                     r4_td;
    logic [mmcm_cw_pkg::PM_W-1:0]    r4_pm;
    logic                            r4_neg;
    // stage 5
    logic [5:0]                      r5_low;
    logic [5:0]                      r5_high;
    logic                            r5_edge;
    logic                            r5_nocnt;
    logic [mmcm_cw_pkg::N3_W-1:0]    r5_n3;
    logic [19:0]                     n5_tr;
    logic [6:0]                      n5_high;
    logic                            n5_edge;
    logic [7:0]                      n5_low;
    logic                            n5_nocnt;
    logic [31:0]                     n5_p;
    // stage 6
    logic [5:0]                      r6_low;
    logic [5:0]                      r6_high;
    logic                            r6_edge;
    logic                            r6_nocnt;
    logic [mmcm_cw_pkg::N3_W-1:0]    r6_n3;
    logic [mmcm_cw_pkg::CPROD_W-1:0] r6_cprod;
    // stage 7, output register
    logic [mmcm_cw_pkg::WORD1_W-1:0] r7_first;
    logic [mmcm_cw_pkg::WORD2_W-1:0] r7_second;
    logic [mmcm_cw_pkg::PCYC_W-1:0]  n7_q0;
    logic [mmcm_cw_pkg::N3_W-1:0]    n7_rem;
    logic [mmcm_cw_pkg::PCYC_W-1:0]  n7_pcyc;
    logic [mmcm_cw_pkg::PCYC_W:0]    n7_t;

    // per-stage ready: a stage loads when empty or when its word moves on
    always_comb begin
        w_rdy[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: wrap negative phase, take magnitude
    always_comb begin
        n1_v = {i_phase[mmcm_cw_pkg::PHASE_W-1], i_phase};
        if (i_phase < 0) begin
            n1_v = n1_v + mmcm_cw_pkg::FULL_TURN;
        end
        n1_abs = n1_v[mmcm_cw_pkg::PHASE_W] ? (~n1_v + 1'b1) : n1_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_div  <= i_divide;
            r1_dn   <= {i_duty, 5'b0};
            r1_a128 <= {n1_abs[mmcm_cw_pkg::AMAG_W-1:0], 7'b0};
            r1_neg  <= n1_v[mmcm_cw_pkg::PHASE_W];
        end
    end

    // stage 2: reciprocal products
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r2_div   <= r1_div;
            r2_dn    <= r1_dn;
            r2_a128  <= r1_a128;
            r2_neg   <= r1_neg;
            r2_dprod <= mmcm_cw_pkg::DPROD_W'(r1_dn) * mmcm_cw_pkg::DUTY_RECIP;
            r2_pprod <= mmcm_cw_pkg::PPROD_W'(r1_a128) * mmcm_cw_pkg::PH_RECIP;
        end
    end

    // stage 3: quotient estimate may be one short, fix with the remainder
    always_comb begin
        n3_dq0  = r2_dprod[mmcm_cw_pkg::DPROD_W-1:32];
        n3_drem = {1'b0, r2_dn}
                  - (($bits(n3_drem))'(n3_dq0) * mmcm_cw_pkg::DUTY_DIV);
        n3_pq0  = r2_pprod[mmcm_cw_pkg::PPROD_W-1:32];
        n3_prem = r2_a128 - (mmcm_cw_pkg::A128_W'(n3_pq0) * mmcm_cw_pkg::PH_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r3_div  <= r2_div;
            r3_neg  <= r2_neg;
            r3_dfix <= n3_dq0 + mmcm_cw_pkg::DFIX_W'(n3_drem >= mmcm_cw_pkg::DUTY_DIV);
            r3_qa   <= n3_pq0 + mmcm_cw_pkg::QA_W'(n3_prem >= mmcm_cw_pkg::PH_DIV);
        end
    end

    // stage 4: scale by the divider
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r4_div <= r3_div;
            r4_neg <= r3_neg;
            r4_td  <= 19'(r3_dfix) * 19'(r3_div);
            r4_pm  <= mmcm_cw_pkg::PM_W'(r3_qa) * mmcm_cw_pkg::PM_W'(r3_div);
        end
    end

    // stage 5: round at the half cycle, clamp high time, fold phase sign
    always_comb begin
        n5_tr    = 20'(r4_td) + (r4_td[8] ? 20'd256 : 20'd0);
        n5_edge  = n5_tr[9];
        n5_high  = n5_tr[16:10];
        n5_nocnt = 1'b0;
        if (n5_high == 7'd0) begin
            n5_edge = 1'b0;
            n5_high = 7'd1;
        end
        if ({1'b0, n5_high} == r4_div) begin
            n5_edge = 1'b1;
            n5_high = 7'(r4_div - 8'd1);
        end
        n5_low = r4_div - {1'b0, n5_high};
        if (r4_div == 8'd1) begin
            // bypass: counter does not count
            n5_edge  = 1'b0;
            n5_high  = 7'd1;
            n5_low   = 8'd1;
            n5_nocnt = 1'b1;
        end
        n5_p = r4_neg ? (32'd0 - 32'(r4_pm)) : 32'(r4_pm);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r5_low   <= n5_low[5:0];
            r5_high  <= n5_high[5:0];
            r5_edge  <= n5_edge;
            r5_nocnt <= n5_nocnt;
            r5_n3    <= n5_p[31:3];
        end
    end

    // stage 6: reciprocal product for the divide by 45
    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r6_low   <= r5_low;
            r6_high  <= r5_high;
            r6_edge  <= r5_edge;
            r6_nocnt <= r5_nocnt;
            r6_n3    <= r5_n3;
            r6_cprod <= mmcm_cw_pkg::CPROD_W'(r5_n3) * mmcm_cw_pkg::CYC_RECIP;
        end
    end

    // stage 7: correct, round at bit 6, pack the words
    always_comb begin
        n7_q0   = r6_cprod[mmcm_cw_pkg::CPROD_W-1:35];
        n7_rem  = r6_n3 - (mmcm_cw_pkg::N3_W'(n7_q0) * mmcm_cw_pkg::CYC_DIV);
        n7_pcyc = n7_q0 + mmcm_cw_pkg::PCYC_W'(n7_rem >= mmcm_cw_pkg::CYC_DIV);
        n7_t    = {1'b0, n7_pcyc} + (n7_pcyc[6] ? 25'd64 : 25'd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r7_first  <= {n7_t[9:7], 1'b0, r6_high, r6_low};
            r7_second <= {r6_edge, r6_nocnt, n7_t[15:10]};
        end
    end

    assign o_in_ready    = w_rdy[0];
    assign o_out_valid   = r_vld[NS-1];
    assign o_first_word  = r7_first;
    assign o_second_word = r7_second;

endmodule

// File: test/mmcm_cw_checker.sv
// checker for mmcm_counter_word_calc_unit: watches both channels, predicts
// the two counter words of every accepted request and compares them in order
// depends on mmcm_cw_pkg for the field widths
module mmcm_cw_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic [mmcm_cw_pkg::DIV_W-1:0]          i_divide,
    input  logic [mmcm_cw_pkg::DUTY_W-1:0]         i_duty,
    input  logic signed [mmcm_cw_pkg::PHASE_W-1:0] i_phase,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic [mmcm_cw_pkg::WORD1_W-1:0]        i_first_word,
    input  logic [mmcm_cw_pkg::WORD2_W-1:0]        i_second_word,
    output int                                     o_errors,
    output int                                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC         = 10;
    localparam logic [31:0] PERCENT_MILLI = 32'd100000;
    localparam longint      MILLI        = 1000;
    localparam longint      TURN_MDEG    = 360000;
    localparam logic [31:0] TURN_DEG     = 32'd360;

    typedef struct packed {
        logic [mmcm_cw_pkg::WORD1_W-1:0] first_word;
        logic [mmcm_cw_pkg::WORD2_W-1:0] second_word;
    } t_counter_words;

    t_counter_words pending_words[$];
    int             err_cnt  = 0;
    int             pend_cnt = 0;

    assign o_errors  = err_cnt;
    assign o_pending = pend_cnt;

    function automatic logic [31:0] round_at_bit(logic [31:0] x, int b);
        return x[b] ? x + (32'd1 << b) : x;
    endfunction

    function automatic t_counter_words calc_counter_words(
        logic [mmcm_cw_pkg::DIV_W-1:0]   div,
        logic [mmcm_cw_pkg::DUTY_W-1:0]  duty,
        logic [mmcm_cw_pkg::PHASE_W-1:0] phase
    );
        logic [31:0]    div32;
        logic [31:0]    duty_q10;
        logic [31:0]    t;
        logic [31:0]    hi;
        logic [31:0]    lo;
        logic           edge_bit;
        logic           nocnt_bit;
        logic [31:0]    pfix;
        logic [31:0]    prod;
        logic [31:0]    pcyc;
        longint         ph;
        longint         v;
        longint         q;
        t_counter_words w;
        div32    = {24'd0, div};
        duty_q10 = ({15'd0, duty} << FRAC) / PERCENT_MILLI;
        if (div == 8'd1) begin
            edge_bit  = 1'b0;
            hi        = 32'd1;
            lo        = 32'd1;
            nocnt_bit = 1'b1;
        end else begin
            // round at the half-cycle bit, bit 9 is the edge
            t        = round_at_bit(duty_q10 * div32, FRAC - 2);
            edge_bit = t[FRAC-1];
            hi       = {25'd0, t[FRAC+6:FRAC]};
            if (hi == 32'd0) begin
                edge_bit = 1'b0;
                hi       = 32'd1;
            end
            if (hi == div32) begin
                edge_bit = 1'b1;
                hi       = div32 - 32'd1;
            end
            lo        = div32 - hi;
            nocnt_bit = 1'b0;
        end
        ph   = $signed(phase);
        v    = (ph < 0) ? ph + TURN_MDEG : ph;
        // signed division truncates toward zero below minus one turn
        q    = (v * 1024) / MILLI;
        pfix = q[31:0];
        prod = pfix * div32;
        pcyc = prod / TURN_DEG;
        t    = round_at_bit(pcyc, FRAC - 4);
        w.first_word  = {t[FRAC-1:FRAC-3], 1'b0, hi[5:0], lo[5:0]};
        w.second_word = {edge_bit, nocnt_bit, t[FRAC+5:FRAC]};
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_counter_words exp_w;
        if (i_rst_n) begin
            // push first so a word accepted and returned at once still lines up
            if (i_in_valid && i_in_ready)
                pending_words.push_back(calc_counter_words(i_divide, i_duty, i_phase));
            if (i_out_valid && i_out_ready) begin
                if (pending_words.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    $display("%0t: unexpected word first=%h second=%h", $time,
                             i_first_word, i_second_word);
                end else begin
                    exp_w = pending_words.pop_front();
                    if (i_first_word !== exp_w.first_word) begin
                        err_cnt = err_cnt + 1;
                        $display("%0t: first_word expected %h actual %h", $time,
                                 exp_w.first_word, i_first_word);
                    end
                    if (i_second_word !== exp_w.second_word) begin
                        err_cnt = err_cnt + 1;
                        $display("%0t: second_word expected %h actual %h", $time,
                                 exp_w.second_word, i_second_word);
                    end
                end
            end
            pend_cnt = pending_words.size();
        end
    end

endmodule

// File: test/tb_top.sv
// top of the counter word calculator test: clock, reset, request stimulus,
// output back-pressure, watchdog and verdict
// depends on mmcm_cw_pkg, mmcm_counter_word_calc_unit and mmcm_cw_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_WORDS = 800;
    localparam int IDLE_LIMIT   = 2000;
    localparam int BURST_SPAN   = 50;

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_ready;
    logic [mmcm_cw_pkg::DIV_W-1:0]          divide;
    logic [mmcm_cw_pkg::DUTY_W-1:0]         duty;
    logic signed [mmcm_cw_pkg::PHASE_W-1:0] phase;
    logic                                   out_valid;
    logic                                   out_ready;
    logic [mmcm_cw_pkg::WORD1_W-1:0]        first_word;
    logic [mmcm_cw_pkg::WORD2_W-1:0]        second_word;
    int                                     errors;
    int                                     pending;
    int                                     idle_cnt = 0;
    bit                                     in_burst  = 1'b0;
    bit                                     out_burst = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    mmcm_counter_word_calc_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_divide      (divide),
        .i_duty        (duty),
        .i_phase       (phase),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_first_word  (first_word),
        .o_second_word (second_word)
    );

    mmcm_cw_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_divide      (divide),
        .i_duty        (duty),
        .i_phase       (phase),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_first_word  (first_word),
        .i_second_word (second_word),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    function automatic int idle_cycles(bit burst);
        return burst ? 0 : int'($urandom_range(10));
    endfunction

    task automatic send_request(logic [7:0] d, logic [16:0] u, int p);
        int gap;
        gap = idle_cycles(in_burst);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        divide   <= d;
        duty     <= u;
        phase    <= p[19:0];
        do @(posedge clk); while (!in_ready);
    endtask

    // no progress on either channel for too long ends the run
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // output back-pressure, one stall draw per word
    initial begin
        int gap;
        int out_cnt;
        out_ready = 1'b0;
        out_cnt   = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (out_cnt % BURST_SPAN == 0)
                out_burst = ($urandom_range(3) == 0);
            gap = idle_cycles(out_burst);
            @(negedge clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            out_cnt++;
        end
    end

    initial begin
        logic [7:0]  d;
        logic [16:0] u;
        int          p;
        int          kind;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        divide   = '0;
        duty     = '0;
        phase    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words: bypass, clamps, truncation, phase wrap, field extremes
        send_request(8'd1,   17'd50000,  0);
        send_request(8'd1,   17'd25000,  270000);
        send_request(8'd2,   17'd50000,  90000);
        send_request(8'd2,   17'd100,    0);
        send_request(8'd2,   17'd99900,  0);
        send_request(8'd10,  17'd100,    -90000);
        send_request(8'd10,  17'd99900,  -1);
        send_request(8'd3,   17'd33333,  359999);
        send_request(8'd64,  17'd50000,  180000);
        send_request(8'd65,  17'd50000,  180000);
        send_request(8'd127, 17'd99900,  360000);
        send_request(8'd128, 17'd99900,  360000);
        send_request(8'd128, 17'd100,    -360000);
        send_request(8'd128, 17'd50000,  -1000);
        send_request(8'd0,   17'd50000,  1000);
        send_request(8'd0,   17'd0,      0);
        send_request(8'd255, 17'd131071, 524287);
        send_request(8'd255, 17'd131071, -524288);
        send_request(8'd200, 17'd0,      -400000);
        send_request(8'd7,   17'd0,      -1);
        send_request(8'd7,   17'd131071, 500000);
        send_request(8'd40,  17'd75000,  45000);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % BURST_SPAN == 0)
                in_burst = ($urandom_range(3) == 0);
            kind = int'($urandom_range(19));
            if (kind < 3) begin
                // anything the field widths allow
                d = 8'($urandom);
                u = 17'($urandom);
                p = int'($urandom);
            end else begin
                if (kind < 5)
                    d = 8'd1;
                else if (kind < 10)
                    d = 8'($urandom_range(16, 2));
                else
                    d = 8'($urandom_range(128, 1));
                u = 17'($urandom_range(99900, 100));
                p = int'($urandom_range(720000)) - 360000;
            end
            send_request(d, u, p);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (2 * mmcm_cw_pkg::STAGES + 10) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
hdl/mmcm_cw_pkg.sv
hdl/mmcm_counter_word_calc_unit.sv
test/mmcm_cw_checker.sv
test/tb_top.sv
